// File: hdl/w4a8_pkg.sv
// ----------------------------------------------------------------------------
// w4a8_pkg
// shared widths, codes and command/status types of the w4a8 row engine
// ----------------------------------------------------------------------------
package w4a8_pkg;

  // item and result field widths
  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 17;
  localparam int DATA_W  = 8;
  localparam int DOT_W   = 22;

  // configuration register widths and reset values
  localparam int IB_W   = 7;
  localparam int OR_W   = 9;
  localparam int PAIR_W = IB_W - 1;
  localparam int CFG_W  = OR_W;
  localparam logic [IB_W-1:0] IN_BLOCKS_RESET = IB_W'(2);
  localparam logic [OR_W-1:0] OUT_ROWS_RESET  = OR_W'(8);

  // configuration register indexes
  localparam logic CFG_IN_BLOCKS = 1'b0;
  localparam logic CFG_OUT_ROWS  = 1'b1;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_W  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // tile geometry
  localparam int ROW_GROUP  = 8;
  localparam int BLOCK_LEN  = 16;
  localparam int TILE_BYTES = ROW_GROUP * BLOCK_LEN;
  localparam int ROW_SHIFT  = 3;
  localparam int BLK_SHIFT  = 4;
  localparam int TILE_SHIFT = 7;
  localparam int COL_SHIFT  = 5;
  localparam int K_W        = 4;

  // size defaults
  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_INPUTS_DEF = 1024;

  // product of an int8 activation and an int4 weight
  localparam int PROD_W = 12;

  typedef struct packed {
    logic capture;
    logic check;
    logic walk;
  } dp_cmd_t;

  typedef struct packed {
    logic is_compute;
    logic item_ok;
    logic walk_last;
    logic pipe_busy;
  } dp_stat_t;

endpackage

// File: hdl/int4_weight_int8_act_gemv_core.sv
// ----------------------------------------------------------------------------
// int4_weight_int8_act_gemv_core
// int4 weight / int8 activation matrix-vector row engine
// ----------------------------------------------------------------------------
//
// channel  | signals                                  | handshake
// ---------+------------------------------------------+--------------------------
// item in  | func, index, data                        | start & !busy
// result   | dot, status                              | done, one cycle, no stall
// config   | cfg_index, cfg_data                      | cfg_valid & cfg_ready
//
// sequence: a load or a rejected item goes from the check state straight to
// done. a compute walks in_blocks/2 column pairs of the row, paced by the
// single read port of the weight memory, one packed byte (two columns) a cycle.
// busy stays high until the cycle after done, so one item is in flight at once.
// reset: synchronous rst clears the sequencer and restores in_blocks = 2,
// out_rows = 8; the memories hold nothing defined until written.
// the result receiver cannot hold off: done marks a single valid cycle.
// config is accepted whenever the engine is idle (cfg_ready = !busy).
//
module int4_weight_int8_act_gemv_core import w4a8_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // item in
  input  logic                    start,
  output logic                    busy,
  input  logic [FUNC_W-1:0]       func,
  input  logic [INDEX_W-1:0]      index,
  input  logic [DATA_W-1:0]       data,
  // result
  output logic                    done,
  output logic signed [DOT_W-1:0] dot,
  output logic                    status,
  // config
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  // configuration registers
  logic [IB_W-1:0] in_blocks;
  logic [OR_W-1:0] out_rows;

  // sequencer to datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_blocks <= IN_BLOCKS_RESET;
      out_rows  <= OUT_ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IN_BLOCKS: in_blocks <= cfg_data[IB_W-1:0];
        CFG_OUT_ROWS:  out_rows  <= cfg_data[OR_W-1:0];
        default:       in_blocks <= in_blocks;
      endcase
    end
  end

  // sequencer: check, walk the tiles of the row, drain, present result
  w4a8_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: memories, range checks and the multiply-accumulate
  w4a8_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_INPUTS (MAX_INPUTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .func      (func),
    .index     (index),
    .data      (data),
    .in_blocks (in_blocks),
    .out_rows  (out_rows),
    .dot       (dot),
    .status    (status)
  );

endmodule

// File: hdl/w4a8_mac.sv
// ----------------------------------------------------------------------------
// w4a8_mac
// two int8 x int4 products a cycle, registered, then accumulated
// ----------------------------------------------------------------------------
module w4a8_mac import w4a8_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  logic                    in_valid,
  input  logic [DATA_W-1:0]       wbyte,
  input  logic [DATA_W-1:0]       act0,
  input  logic [DATA_W-1:0]       act1,
  output logic signed [DOT_W-1:0] acc,
  output logic                    busy
);

  logic signed [DATA_W-1:0] a0s;
  logic signed [DATA_W-1:0] a1s;
  logic signed [3:0]        w0s;
  logic signed [3:0]        w1s;
  logic signed [PROD_W-1:0] prod0;
  logic signed [PROD_W-1:0] prod1;
  logic signed [PROD_W-1:0] prod0_next;
  logic signed [PROD_W-1:0] prod1_next;
  logic                     prod_valid;

  assign a0s = act0;
  assign a1s = act1;
  // low nibble goes with the first block of the pair, high nibble with the second
  assign w0s = wbyte[3:0];
  assign w1s = wbyte[7:4];

  assign prod0_next = PROD_W'(a0s) * PROD_W'(w0s);
  assign prod1_next = PROD_W'(a1s) * PROD_W'(w1s);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod0 <= prod0_next;
    prod1 <= prod1_next;
    if (clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + DOT_W'(prod0) + DOT_W'(prod1);
    end
  end

  assign busy = prod_valid;

endmodule

// File: hdl/w4a8_dp.sv
// ----------------------------------------------------------------------------
// w4a8_dp
// item registers, range checks, weight and activation memories, address walk
// ----------------------------------------------------------------------------
module w4a8_dp import w4a8_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [FUNC_W-1:0]       func,
  input  logic [INDEX_W-1:0]      index,
  input  logic [DATA_W-1:0]       data,
  input  logic [IB_W-1:0]         in_blocks,
  input  logic [OR_W-1:0]         out_rows,
  output logic signed [DOT_W-1:0] dot,
  output logic                    status
);

  localparam int WDEPTH = (MAX_ROWS / ROW_GROUP) * (MAX_INPUTS / (2 * BLOCK_LEN)) * TILE_BYTES;
  localparam int WA_W   = $clog2(WDEPTH);
  localparam int AA_W   = $clog2(MAX_INPUTS);
  localparam int GRP_W  = (MAX_ROWS > ROW_GROUP) ? $clog2(MAX_ROWS / ROW_GROUP) : 1;
  localparam int GP_W   = GRP_W + PAIR_W;
  localparam int GRPS_W = OR_W - ROW_SHIFT + 1;
  localparam int TL_W   = GRPS_W + PAIR_W;
  localparam int WL_W   = TL_W + TILE_SHIFT;
  localparam int COLS_W = PAIR_W + COL_SHIFT;
  localparam logic [K_W-1:0] K_LAST = K_W'(BLOCK_LEN - 1);

  // captured item
  logic [FUNC_W-1:0]  func_q;
  logic [INDEX_W-1:0] index_q;
  logic [DATA_W-1:0]  data_q;

  // range checks
  logic [PAIR_W-1:0] pairs;
  logic [OR_W:0]     rows_sum;
  logic [GRPS_W-1:0] groups;
  logic [TL_W-1:0]   tiles;
  logic [WL_W-1:0]   wlimit;
  logic [COLS_W-1:0] cols;
  logic              cfg_ok;
  logic              w_ok;
  logic              a_ok;
  logic              r_ok;
  logic              item_ok;

  // walk
  logic [GRP_W-1:0] grp;
  logic [GP_W-1:0]  gp;
  logic [WA_W-1:0]  wbase;
  logic [WA_W-1:0]  waddr;
  logic [AA_W-1:0]  aaddr;
  logic [K_W-1:0]   kcnt;
  logic [PAIR_W-1:0] pleft;
  logic             walk_last;

  // memories
  logic [DATA_W-1:0] wmem [WDEPTH];
  logic [DATA_W-1:0] amem [MAX_INPUTS];
  logic              wmem_we;
  logic              amem_we;
  logic [DATA_W-1:0] wbyte;
  logic [DATA_W-1:0] act0;
  logic [DATA_W-1:0] act1;
  logic              rd_valid;
  logic              mac_busy;
  logic              status_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q  <= func;
      index_q <= index;
      data_q  <= data;
    end
  end

  assign pairs    = in_blocks[IB_W-1:1];
  assign rows_sum = {1'b0, out_rows} + (OR_W + 1)'(ROW_GROUP - 1);
  assign groups   = rows_sum[OR_W:ROW_SHIFT];
  assign tiles    = TL_W'(groups) * TL_W'(pairs);
  assign wlimit   = {tiles, {TILE_SHIFT{1'b0}}};
  assign cols     = {pairs, {COL_SHIFT{1'b0}}};

  assign cfg_ok = (pairs != '0) && (32'(cols) <= 32'(MAX_INPUTS));
  assign w_ok   = (32'(index_q) < 32'(wlimit)) && (32'(index_q) < 32'(WDEPTH));
  assign a_ok   = 32'(index_q) < 32'(cols);
  assign r_ok   = (32'(index_q) < 32'(out_rows)) && (32'(index_q) < 32'(MAX_ROWS));

  always_comb begin
    unique case (func_q)
      FUNC_LOAD_W:  item_ok = cfg_ok && w_ok;
      FUNC_LOAD_A:  item_ok = cfg_ok && a_ok;
      FUNC_COMPUTE: item_ok = cfg_ok && r_ok;
      default:      item_ok = 1'b0;
    endcase
  end

  // first byte of the row inside its first tile
  assign grp   = GRP_W'(index_q >> ROW_SHIFT);
  assign gp    = GP_W'(grp) * GP_W'(pairs);
  assign wbase = (WA_W'(gp) << TILE_SHIFT) + (WA_W'(index_q[ROW_SHIFT-1:0]) << BLK_SHIFT);

  assign walk_last = (kcnt == K_LAST) && (pleft == '0);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      waddr <= wbase;
      aaddr <= '0;
      kcnt  <= '0;
      pleft <= pairs - PAIR_W'(1);
    end else if (cmd.walk) begin
      kcnt <= kcnt + K_W'(1);
      if (kcnt == K_LAST) begin
        // jump to the same row of the next tile, next column pair
        waddr <= waddr + WA_W'(TILE_BYTES - BLOCK_LEN + 1);
        aaddr <= aaddr + AA_W'(BLOCK_LEN + 1);
        pleft <= pleft - PAIR_W'(1);
      end else begin
        waddr <= waddr + WA_W'(1);
        aaddr <= aaddr + AA_W'(1);
      end
    end
  end

  assign wmem_we = cmd.check && item_ok && (func_q == FUNC_LOAD_W);
  assign amem_we = cmd.check && item_ok && (func_q == FUNC_LOAD_A);

  always_ff @(posedge clk) begin
    if (wmem_we) begin
      wmem[WA_W'(index_q)] <= data_q;
    end
    wbyte <= wmem[waddr];
  end

  always_ff @(posedge clk) begin
    if (amem_we) begin
      amem[AA_W'(index_q)] <= data_q;
    end
    act0 <= amem[aaddr];
    act1 <= amem[aaddr + AA_W'(BLOCK_LEN)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      status_q <= ~item_ok;
    end
  end

  w4a8_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .clear    (cmd.check),
    .in_valid (rd_valid),
    .wbyte    (wbyte),
    .act0     (act0),
    .act1     (act1),
    .acc      (dot),
    .busy     (mac_busy)
  );

  assign status = status_q;

  assign stat.is_compute = func_q == FUNC_COMPUTE;
  assign stat.item_ok    = item_ok;
  assign stat.walk_last  = walk_last;
  assign stat.pipe_busy  = rd_valid | mac_busy;

endmodule

// File: hdl/w4a8_ctrl.sv
// ----------------------------------------------------------------------------
// w4a8_ctrl
// sequencer: capture, check, walk the row, drain the pipe, issue the result
// ----------------------------------------------------------------------------
module w4a8_ctrl import w4a8_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.check   = 1'b0;
    cmd.walk    = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = start;
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.is_compute && stat.item_ok) begin
          state_next = S_WALK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

endmodule
